@@ design/swmt_pkg.sv @@
`timescale 1ns / 1ps

package swmt_pkg;

    localparam int TIME_W         = 32;
    localparam int USED_W         = 4;
    localparam int WINDOW_DEFAULT = 11;
    localparam int WINDOW_MAX     = 64;
    // age field sized for the widest window allowed
    localparam int AGE_W          = $clog2(WINDOW_MAX);

    typedef struct packed {
        logic              valid;
        logic [AGE_W-1:0]  age;
        logic [TIME_W-1:0] value;
    } cell_t;

endpackage

@@ design/swmt_cell.sv @@
`timescale 1ns / 1ps

module swmt_cell
    import swmt_pkg::*;
#(
    parameter bit               FIRST    = 1'b0,
    parameter logic [AGE_W-1:0] AGE_LAST = AGE_W'(WINDOW_DEFAULT - 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic              full,
    input  logic [TIME_W-1:0] new_time,
    input  cell_t             right_st,
    input  cell_t             left_r,
    input  logic              left_le,
    input  logic              ev_in,
    output logic              ev_out,
    output cell_t             r_out,
    output logic              le_out,
    output cell_t             st
);

    cell_t st_reg;
    cell_t st_next;
    logic  evict;

    // oldest entry leaves when the window is full
    assign evict  = full && st_reg.valid && (st_reg.age == AGE_LAST);
    assign ev_out = ev_in | evict;

    // entry at this slot once the evicted one is squeezed out
    assign r_out  = ev_out ? right_st : st_reg;
    assign le_out = r_out.valid && (r_out.value <= new_time);

    always_comb
    begin
        if (le_out)
        begin
            st_next     = r_out;
            st_next.age = r_out.age + 1'b1;
        end
        else if (FIRST || left_le)
        begin
            st_next.valid = 1'b1;
            st_next.age   = '0;
            st_next.value = new_time;
        end
        else
        begin
            st_next     = left_r;
            st_next.age = left_r.age + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (shift_en)
        begin
            st_reg <= st_next;
        end
    end

    assign st = st_reg;

endmodule

@@ design/sliding_window_median_time_top.sv @@
`timescale 1ns / 1ps

// Sliding-window median of block timestamps.
//
// Input channel: block_time with in_valid / in_stall. A beat is taken on a
// rising edge with in_valid high and in_stall low. Output channel:
// median_time and used_count with out_valid / out_stall, one result beat per
// input beat, in order.
//
// The window is a row of WINDOW cells kept in ascending order. Each cell
// holds a time and its age; on every input beat the oldest entry (full
// window only) is squeezed out and the new time drops into its sorted slot,
// all cells moving at most one place in the same cycle.
// used_count = entries held, median_time = cell at index used_count/2.
//
// Path: each input beat updates the cell row, then its result is loaded
// into the result register. Throughput: one beat per cycle while the
// output is not stalled.
// Reset: the window is empty, no result pending, out_valid low.
// Output stall: the result register holds; one more beat can sit in the
// pending stage, after which in_stall is raised until the output drains.
module sliding_window_median_time_top
    import swmt_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [TIME_W-1:0] block_time,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [TIME_W-1:0] median_time,
    output logic [USED_W-1:0] used_count
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic              in_acc;
    logic              move;
    logic              full;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              pend_reg;
    logic              pend_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [TIME_W-1:0] median_reg;
    logic [USED_W-1:0] used_reg;

    cell_t             st_w [WINDOW];
    cell_t             r_w  [WINDOW];
    logic              le_w [WINDOW];
    logic              ev_w [WINDOW+1];

    logic [CNT_W+USED_W-1:0] cnt_ext;
    logic [CNT_W+IDX_W-1:0]  half_ext;
    logic [IDX_W-1:0]        med_idx;

    // handshake: pending beat moves out when the result register is free
    assign move     = pend_reg && (!out_valid_reg || !out_stall);
    assign in_stall = pend_reg && out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;

    assign full     = (cnt_reg == CNT_W'(WINDOW));
    assign ev_w[0]  = 1'b0;

    // sorted cell row
    for (genvar i = 0; i < WINDOW; i++)
    begin : g_cell
        cell_t right_st;
        cell_t left_r;
        logic  left_le;

        if (i == WINDOW - 1)
        begin : g_last
            assign right_st = '0;
        end
        else
        begin : g_mid
            assign right_st = st_w[i+1];
        end

        if (i == 0)
        begin : g_head
            assign left_r  = '0;
            assign left_le = 1'b0;
        end
        else
        begin : g_body
            assign left_r  = r_w[i-1];
            assign left_le = le_w[i-1];
        end

        swmt_cell #(
            .FIRST    (i == 0),
            .AGE_LAST (AGE_W'(WINDOW - 1))
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (in_acc),
            .full     (full),
            .new_time (block_time),
            .right_st (right_st),
            .left_r   (left_r),
            .left_le  (left_le),
            .ev_in    (ev_w[i]),
            .ev_out   (ev_w[i+1]),
            .r_out    (r_w[i]),
            .le_out   (le_w[i]),
            .st       (st_w[i])
        );
    end

    // fill count saturates at WINDOW
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_acc && !full)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc)
        begin
            pend_next = 1'b1;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // median pick: cell at index count/2 of the row after the update
    assign cnt_ext  = {{USED_W{1'b0}}, cnt_reg};
    assign half_ext = {{IDX_W{1'b0}}, cnt_reg >> 1};
    assign med_idx  = half_ext[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            median_reg <= st_w[med_idx].value;
            used_reg   <= cnt_ext[USED_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign median_time = median_reg;
    assign used_count  = used_reg;

    // checks
    logic [WINDOW-1:0] valid_vec;
    logic [WINDOW-1:0] order_ok;

    for (genvar i = 0; i < WINDOW; i++)
    begin : g_chk
        assign valid_vec[i] = st_w[i].valid;
        if (i == WINDOW - 1)
        begin : g_end
            assign order_ok[i] = 1'b1;
        end
        else
        begin : g_pair
            assign order_ok[i] = !st_w[i+1].valid ||
                                 (st_w[i].valid && (st_w[i].value <= st_w[i+1].value));
        end
    end

    a_count_matches : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(cnt_reg))
        else $error("valid cells differ from fill count");

    a_row_sorted : assert property (@(posedge clk) disable iff (!rst_n)
        &order_ok)
        else $error("cell row out of order");

    a_full_evicts : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> ev_w[WINDOW])
        else $error("full window with no oldest entry");

    a_pend_drains : assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("pending result not moved to output");

endmodule
